### rtl/rrss_pkg.sv
`default_nettype none
package rrss_pkg;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_ALLOCATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SCHEDULE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_SCAN,
    S_SCHED_SCAN,
    S_MEM_READ,
    S_RESULT
  } state_t;

  // what the result address field is taken from
  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_HELD,
    ADDR_MEM
  } addr_src_t;

  typedef struct packed {
    logic take;         // accept the transaction, latch fields, apply release
    logic step;         // advance the scan
    logic alloc_claim;  // claim the scanned dead slot
    logic alloc_full;   // report a full table
    logic sched_pick;   // move to the scanned live slot and read its address
    logic sched_stay;   // no other slot live: stay or report none
    logic load_out;     // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             hit;
    logic             last;
    logic             out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/rrss_ctrl.sv
`default_nettype none
module rrss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rrss_pkg::sts_t sts,
  output rrss_pkg::cmd_t     cmd
);
  import rrss_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.req == REQ_ALLOCATE) begin
            state_next = S_ALLOC_SCAN;
          end else if (sts.req == REQ_SCHEDULE) begin
            state_next = S_SCHED_SCAN;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_ALLOC_SCAN: begin
        if (sts.hit || sts.last) begin
          state_next = S_RESULT;
        end
      end
      S_SCHED_SCAN: begin
        if (sts.hit) begin
          state_next = S_MEM_READ;
        end else if (sts.last) begin
          state_next = S_RESULT;
        end
      end
      S_MEM_READ: state_next = S_RESULT;
      S_RESULT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      S_ALLOC_SCAN: begin
        cmd.alloc_claim = sts.hit;
        cmd.alloc_full  = !sts.hit && sts.last;
        cmd.step        = !sts.hit && !sts.last;
      end
      S_SCHED_SCAN: begin
        cmd.sched_pick = sts.hit;
        cmd.sched_stay = !sts.hit && sts.last;
        cmd.step       = !sts.hit && !sts.last;
      end
      S_MEM_READ: begin
      end
      S_RESULT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/rrss_dp.sv
`default_nettype none
module rrss_dp #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rrss_pkg::REQ_W-1:0]    req_type,
  input  wire logic [rrss_pkg::SLOT_W-1:0]   slot_index,
  input  wire logic [rrss_pkg::ADDR_W-1:0]   resume_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rrss_pkg::STAT_W-1:0]        status,
  output logic [rrss_pkg::SLOT_W-1:0]        slot,
  output logic [rrss_pkg::ADDR_W-1:0]        next_address,
  input  wire rrss_pkg::cmd_t                cmd,
  output rrss_pkg::sts_t                     sts
);
  import rrss_pkg::*;

  localparam int unsigned PTR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CMP_W = PTR_W + SLOT_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(SLOT_COUNT - 1);
  localparam logic [CMP_W-1:0] COUNT_V  = CMP_W'(SLOT_COUNT);

  logic [SLOT_COUNT-1:0] live;
  logic [ADDR_W-1:0]     mem [SLOT_COUNT];
  logic [ADDR_W-1:0]     rdata;
  logic [PTR_W-1:0]      cur;
  logic [PTR_W-1:0]      cnt;
  logic [PTR_W-1:0]      cand;
  logic [REQ_W-1:0]      req_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [STAT_W-1:0]     res_status;
  logic [PTR_W-1:0]      res_ptr;
  addr_src_t             res_src;

  logic [CMP_W-1:0]        idx_ext;
  logic [PTR_W+SLOT_W-1:0] ptr_ext;
  logic [PTR_W-1:0]        cur_inc;
  logic [PTR_W-1:0]        cand_inc;
  logic [PTR_W-1:0]        cnt_first;
  logic [ADDR_W-1:0]       res_addr;
  logic                    mem_we;
  logic [PTR_W-1:0]        mem_waddr;
  logic [ADDR_W-1:0]       mem_wdata;

  assign idx_ext   = {{(PTR_W + 1){1'b0}}, slot_index};
  assign ptr_ext   = {{SLOT_W{1'b0}}, res_ptr};
  assign cur_inc   = (cur == LAST_PTR) ? '0 : cur + 1'b1;
  assign cand_inc  = (cand == LAST_PTR) ? '0 : cand + 1'b1;
  assign cnt_first = (req_type == REQ_SCHEDULE) ? PTR_W'(1) : '0;

  // schedule stores its address on acceptance; allocate on the claim
  assign mem_we    = (cmd.take && req_type == REQ_SCHEDULE) || cmd.alloc_claim;
  assign mem_waddr = cmd.take ? cur : cnt;
  assign mem_wdata = cmd.take ? resume_address : addr_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.sched_pick) begin
      rdata <= mem[cand];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      cur  <= '0;
    end else begin
      if (cmd.take && req_type == REQ_RELEASE && idx_ext < COUNT_V) begin
        live[idx_ext[PTR_W-1:0]] <= 1'b0;
      end
      if (cmd.alloc_claim) begin
        live[cnt] <= 1'b1;
      end
      if (cmd.sched_pick) begin
        cur <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_q      <= req_type;
      addr_q     <= resume_address;
      cnt        <= cnt_first;
      cand       <= cur_inc;
      res_status <= ST_OK;
      res_ptr    <= '0;
      res_src    <= ADDR_ZERO;
    end else begin
      if (cmd.step) begin
        cnt  <= cnt + 1'b1;
        cand <= cand_inc;
      end
      if (cmd.alloc_claim) begin
        res_ptr <= cnt;
      end
      if (cmd.alloc_full) begin
        res_status <= ST_FULL;
      end
      if (cmd.sched_pick) begin
        res_ptr <= cand;
        res_src <= ADDR_MEM;
      end
      if (cmd.sched_stay) begin
        if (live[cur]) begin
          res_ptr <= cur;
          res_src <= ADDR_HELD;
        end else begin
          res_status <= ST_NONE;
        end
      end
    end
  end

  always_comb begin
    case (res_src)
      ADDR_HELD: res_addr = addr_q;
      ADDR_MEM:  res_addr = rdata;
      default:   res_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      slot         <= ptr_ext[SLOT_W-1:0];
      next_address <= res_addr;
    end
  end

  always_comb begin
    sts.req      = req_type;
    sts.out_free = !out_valid || !out_stall;
    if (req_q == REQ_SCHEDULE) begin
      sts.hit  = live[cand];
      sts.last = (cnt == LAST_PTR);
    end else begin
      sts.hit  = !live[cnt];
      sts.last = (cnt == LAST_PTR);
    end
  end

endmodule
`default_nettype wire

### rtl/round_robin_slot_scheduler.sv
`default_nettype none
// Release and unknown requests go straight from acceptance to the result state;
// allocate scans up to SLOT_COUNT slots, schedule up to SLOT_COUNT - 1 other slots.
// The scan tests one slot a cycle; a schedule hit adds one address-memory read.
// One transaction at a time: a new request is accepted only after the result is loaded.
// Reset: every slot dead, current slot 0, no result pending; addresses kept.
module round_robin_slot_scheduler #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rrss_pkg::REQ_W-1:0]  req_type,
  input  wire logic [rrss_pkg::SLOT_W-1:0] slot_index,
  input  wire logic [rrss_pkg::ADDR_W-1:0] resume_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rrss_pkg::STAT_W-1:0]      status,
  output logic [rrss_pkg::SLOT_W-1:0]      slot,
  output logic [rrss_pkg::ADDR_W-1:0]      next_address
);
  import rrss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrss_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_type       (req_type),
    .slot_index     (slot_index),
    .resume_address (resume_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .slot           (slot),
    .next_address   (next_address),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
`default_nettype wire
